### rtl/sti_pkg.sv
`default_nettype none

package sti_pkg;

	localparam int CMD_W    = 2;
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 16;
	localparam int OFFSET_W = 16;
	localparam int VALUE_W  = 19;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	// Gain is Q4.12, so the product drops this many fraction bits.
	localparam int GAIN_FRAC = 12;

	localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PLUG_SRC  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PLUG_CONST = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNPLUG    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd1;

	localparam logic signed [GAIN_W-1:0]   GAIN_RESET   = 16'sd4096;
	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 16'sd0;

	// Selected value and flags handed from the pickup stage to the scaler.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sel;
		logic                       following;
		logic                       pending;
	} pick_t;

endpackage

`default_nettype wire

### rtl/sti_pickup.sv
`default_nettype none

module sti_pickup (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire logic [sti_pkg::CMD_W-1:0]           cmd,
	input  wire logic signed [sti_pkg::SAMPLE_W-1:0] sample,
	output sti_pkg::pick_t                           pick
);
	import sti_pkg::*;

	logic signed [SAMPLE_W-1:0] held_q, held_n;
	logic                       follow_q, follow_n;
	logic                       pending_q, pending_n;
	logic                       above_q, above_n;
	logic                       reached;

	// Source has come around to the held value from its starting side.
	assign reached = above_q ? (sample <= held_q) : (sample >= held_q);

	always_comb begin
		held_n    = held_q;
		follow_n  = follow_q;
		pending_n = pending_q;
		above_n   = above_q;
		case (cmd)
			CMD_TICK: begin
				if (pending_q && reached) begin
					follow_n  = 1'b1;
					pending_n = 1'b0;
					above_n   = 1'b0;
				end
			end
			CMD_PLUG_SRC: begin
				if (sample == held_q) begin
					follow_n  = 1'b1;
					pending_n = 1'b0;
					above_n   = 1'b0;
				end else begin
					follow_n  = 1'b0;
					pending_n = 1'b1;
					above_n   = (sample > held_q);
				end
			end
			CMD_PLUG_CONST: begin
				held_n    = sample;
				follow_n  = 1'b0;
				pending_n = 1'b0;
				above_n   = 1'b0;
			end
			CMD_UNPLUG: begin
				if (follow_q) begin
					held_n = sample;
				end
				follow_n  = 1'b0;
				pending_n = 1'b0;
				above_n   = 1'b0;
			end
			default: begin
				held_n = held_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			follow_q  <= 1'b0;
			pending_q <= 1'b0;
			above_q   <= 1'b0;
		end else if (load) begin
			held_q    <= held_n;
			follow_q  <= follow_n;
			pending_q <= pending_n;
			above_q   <= above_n;
		end
	end

	assign pick.sel       = follow_n ? sample : held_n;
	assign pick.following = follow_n;
	assign pick.pending   = pending_n;

endmodule

`default_nettype wire

### rtl/sti_scale.sv
`default_nettype none

module sti_scale (
	input  wire logic                                clk,
	input  wire logic                                load,
	input  sti_pkg::pick_t                           pick,
	input  wire logic signed [sti_pkg::GAIN_W-1:0]   gain,
	input  wire logic signed [sti_pkg::OFFSET_W-1:0] offset,
	output logic signed [sti_pkg::VALUE_W-1:0]       value,
	output logic                                     following,
	output logic                                     pending
);
	import sti_pkg::*;

	localparam int PROD_W = SAMPLE_W + GAIN_W;
	localparam int Q_W    = PROD_W - GAIN_FRAC;
	localparam int SUM_W  = Q_W + 1;

	localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((1 <<< (VALUE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] VMIN = -SUM_W'(1 <<< (VALUE_W - 1));

	logic signed [PROD_W-1:0] prod;
	logic signed [Q_W-1:0]    quo;
	logic signed [SUM_W-1:0]  sum;
	logic signed [VALUE_W-1:0] sat;

	// Arithmetic shift rounds toward minus infinity.
	assign prod = pick.sel * gain;
	assign quo  = Q_W'(prod >>> GAIN_FRAC);
	assign sum  = SUM_W'(quo) + SUM_W'(offset);

	always_comb begin
		if (sum > VMAX) begin
			sat = VMAX[VALUE_W-1:0];
		end else if (sum < VMIN) begin
			sat = VMIN[VALUE_W-1:0];
		end else begin
			sat = sum[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value     <= sat;
			following <= pick.following;
			pending   <= pick.pending;
		end
	end

endmodule

`default_nettype wire

### rtl/soft_takeover_signal_input.sv
// Channel   Handshake             Payload
// --------  --------------------  ---------------------------------
// in        in_valid / in_stall   cmd[1:0], sample[15:0] (Q1.15)
// out       out_valid / out_stall value[18:0] (Q4.15), following, pending
// cfg       cfg_we (no wait)      cfg_index[0], cfg_data[15:0]
//
// Two stages: the pickup state updates at the input transfer and the
// selected value lands in the _s1 register; from there it is multiplied
// by gain, offset is added and it saturates into the output register.
// Throughput is one item per cycle while out is not stalled.
// Reset clears the pickup state, the stage valid bits and loads gain 1.0,
// offset 0. A stall on out holds both stages and backs up into in_stall.
`default_nettype none

module soft_takeover_signal_input (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [sti_pkg::CMD_W-1:0]           cmd,
	input  wire logic signed [sti_pkg::SAMPLE_W-1:0] sample,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [sti_pkg::VALUE_W-1:0]       value,
	output logic                                     following,
	output logic                                     pending,
	input  wire logic                                cfg_we,
	input  wire logic [sti_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sti_pkg::CFG_W-1:0]           cfg_data
);
	import sti_pkg::*;

	logic signed [GAIN_W-1:0]   gain_q;
	logic signed [OFFSET_W-1:0] offset_q;

	pick_t pick_c;
	pick_t pick_s1;
	logic  valid_s1;
	logic  adv_out;
	logic  adv_s1;
	logic  in_xfer;

	// Output register frees when empty or when its transfer completes.
	assign adv_out  = !out_valid || !out_stall;
	// Stage 1 may load when it is empty or moving on into the output.
	assign adv_s1   = !valid_s1 || adv_out;
	assign in_stall = !adv_s1;
	assign in_xfer  = in_valid && adv_s1;

	// Configuration: the user must write it only while idle (not enforced here), no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:   gain_q   <= cfg_data;
				REG_OFFSET: offset_q <= cfg_data;
				default:    gain_q   <= gain_q;
			endcase
		end
	end

	// Pickup state advances on each input transfer.
	sti_pickup u_pickup (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (in_xfer),
		.cmd    (cmd),
		.sample (sample),
		.pick   (pick_c)
	);

	// Stage 1: hold the selected value and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pick_s1 <= pick_c;
		end
	end

	// Output stage valid: advance with stage 1, drop on transfer out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_out) begin
			out_valid <= valid_s1;
		end
	end

	// Scale, offset and saturate into the output register.
	sti_scale u_scale (
		.clk       (clk),
		.load      (adv_out && valid_s1),
		.pick      (pick_s1),
		.gain      (gain_q),
		.offset    (offset_q),
		.value     (value),
		.following (following),
		.pending   (pending)
	);

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;
	import sti_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 48;
	localparam int JAM_CYCLES  = 90;
	localparam int JAM_PHASE   = 2;
	localparam int CALM_PHASE  = 4;
	localparam int MAX_REPORTS = 40;

	// One transfer on the input channel.
	typedef struct {
		logic [CMD_W-1:0]           cmd;
		logic signed [SAMPLE_W-1:0] sample;
	} pick_item_t;

	// One transfer on the output channel.
	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      following;
		logic                      pending;
	} pick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                       in_valid = 1'b0;
	wire logic                  in_stall;
	logic [CMD_W-1:0]           cmd = CMD_TICK;
	logic signed [SAMPLE_W-1:0] sample = '0;
	wire logic                  out_valid;
	logic                       out_stall = 1'b0;
	wire logic signed [VALUE_W-1:0] value;
	wire logic                  following;
	wire logic                  pending;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_GAIN;
	logic [CFG_W-1:0]           cfg_data = '0;

	soft_takeover_signal_input u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.following (following),
		.pending   (pending),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Items waiting to be offered, and results waiting to be seen, oldest first.
	pick_item_t   pickup_items[$];
	pick_result_t scaled_expect[$];

	// Shadow of the block: configuration and pickup state.
	logic signed [GAIN_W-1:0]   gain_q   = GAIN_RESET;
	logic signed [OFFSET_W-1:0] offset_q = OFFSET_RESET;
	logic signed [SAMPLE_W-1:0] pick_held = '0;
	logic                       pick_follow = 1'b0;
	logic                       pick_pending = 1'b0;
	logic                       pick_above = 1'b0;

	// Stimulus controls shared with the driver and the monitor.
	bit calm = 1'b0;
	bit jam_req = 1'b0;
	bit jam_done = 1'b0;
	int hold_left = 0;
	int err_count = 0;
	int cycles = 0;
	int queued_total = 0;
	pick_result_t want;

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Advance the shadow pickup state by one item and work out the scaled result.
	function automatic pick_result_t predict_takeover(pick_item_t it);
		pick_result_t r;
		logic signed [SAMPLE_W-1:0] chosen;
		longint scaled;
		case (it.cmd)
			CMD_TICK: begin
				// Pick up once the source reaches the held value from its starting side.
				if (pick_pending && ((pick_above && it.sample <= pick_held) ||
						(!pick_above && it.sample >= pick_held))) begin
					pick_follow  = 1'b1;
					pick_pending = 1'b0;
					pick_above   = 1'b0;
				end
			end
			CMD_PLUG_SRC: begin
				pick_follow = 1'b0;
				if (it.sample == pick_held) begin
					// Equal at plug time: follow right away.
					pick_follow  = 1'b1;
					pick_pending = 1'b0;
					pick_above   = 1'b0;
				end else begin
					pick_pending = 1'b1;
					pick_above   = it.sample > pick_held;
				end
			end
			CMD_PLUG_CONST: begin
				pick_held    = it.sample;
				pick_follow  = 1'b0;
				pick_pending = 1'b0;
				pick_above   = 1'b0;
			end
			default: begin
				// Unplug: capture the live source only when it was being followed.
				if (pick_follow)
					pick_held = it.sample;
				pick_follow  = 1'b0;
				pick_pending = 1'b0;
				pick_above   = 1'b0;
			end
		endcase
		chosen = pick_follow ? it.sample : pick_held;
		// Q1.15 times Q4.12, drop 12 fraction bits rounding down, add offset, clamp.
		scaled = (longint'(chosen) * longint'(gain_q)) >>> GAIN_FRAC;
		scaled = scaled + longint'(offset_q);
		if (scaled > 262143)
			scaled = 262143;
		if (scaled < -262144)
			scaled = -262144;
		r.value     = scaled[VALUE_W-1:0];
		r.following = pick_follow;
		r.pending   = pick_pending;
		return r;
	endfunction

	// Driver: predict at each input transfer, then offer the next item or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd      <= CMD_TICK;
			sample   <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				scaled_expect.push_back(predict_takeover(pickup_items[0]));
				pickup_items.delete(0);
			end
			if (in_valid && in_stall) begin
				// Hold the stalled transfer as it is.
			end else if (pickup_items.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
				in_valid <= 1'b1;
				cmd      <= pickup_items[0].cmd;
				sample   <= pickup_items[0].sample;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each output transfer against the oldest expectation, then
	// decide the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (scaled_expect.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: unexpected result: value %0d following %0b pending %0b",
							$time, value, following, pending);
				end else begin
					want = scaled_expect.pop_front();
					if (value !== want.value) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("%0t: value mismatch: expected %0d actual %0d",
								$time, want.value, value);
					end
					if (following !== want.following) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("%0t: following mismatch: expected %0b actual %0b",
								$time, want.following, following);
					end
					if (pending !== want.pending) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("%0t: pending mismatch: expected %0b actual %0b",
								$time, want.pending, pending);
					end
				end
			end
			// One long hold-off while the sender keeps offering, so both
			// stages fill and the block backs up into in_stall.
			if (jam_req && !jam_done) begin
				hold_left = JAM_CYCLES;
				jam_done  = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 37);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic int clamp16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	task automatic add_item(logic [CMD_W-1:0] c, int s);
		pick_item_t it;
		it.cmd    = c;
		it.sample = s[SAMPLE_W-1:0];
		pickup_items.push_back(it);
		queued_total++;
	endtask

	// A full takeover: set a constant, plug a source, sweep it toward and to or past
	// the held value, follow for a while, sometimes unplug.
	task automatic add_pickup_run();
		int held;
		int start;
		int goal;
		int steps;
		int d;
		int j;
		held = int'(rand_sample());
		add_item(CMD_PLUG_CONST, held);
		start = ($urandom_range(7) == 0) ? held : int'(rand_sample());
		add_item(CMD_PLUG_SRC, start);
		d = $urandom_range(0, 300);
		goal = clamp16((start > held) ? held - d : held + d);
		steps = $urandom_range(2, 7);
		for (int k = 1; k <= steps; k++) begin
			j = (k == steps) ? 32 : $urandom_range(0, 64);
			add_item(CMD_TICK, clamp16(start + (goal - start) * k / steps + j - 32));
		end
		repeat ($urandom_range(0, 4))
			add_item(CMD_TICK, int'(rand_sample()));
		if ($urandom_range(1) == 0)
			add_item(CMD_UNPLUG, int'(rand_sample()));
	endtask

	// Pause the sender until every queued item has been answered.
	task automatic wait_drained();
		while (pickup_items.size() != 0 || scaled_expect.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GAIN:   gain_q   = data;
			REG_OFFSET: offset_q = data;
			default: ;
		endcase
	endtask

	int gain_set[PHASES]   = '{-32768, 32767, 4096, 32767, -32768, 0, -1, 1, 0, 0};
	int offset_set[PHASES] = '{-32768, 32767, 0, -32768, 32767, 12345, 1, -1, 0, 0};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at reset gain 1.0 and offset 0.
		add_item(CMD_TICK, 32767);         // tick with nothing plugged
		add_item(CMD_PLUG_SRC, 0);         // source equals held value: follow at once
		add_item(CMD_TICK, -32768);
		add_item(CMD_TICK, 32767);
		add_item(CMD_UNPLUG, 12345);       // capture the followed source
		add_item(CMD_PLUG_SRC, 32767);     // starts above
		add_item(CMD_TICK, 20000);         // still above
		add_item(CMD_TICK, 12345);         // reaches it exactly
		add_item(CMD_PLUG_SRC, -32768);    // plug while following
		add_item(CMD_PLUG_SRC, 30000);     // plug while pending restarts the pickup
		add_item(CMD_TICK, -32768);        // crosses from above
		add_item(CMD_PLUG_SRC, 0);
		add_item(CMD_UNPLUG, 555);         // unplug while pending keeps held value
		add_item(CMD_PLUG_SRC, 32767);
		add_item(CMD_PLUG_CONST, -32768);  // constant while pending cancels
		add_item(CMD_PLUG_SRC, -32768);    // equal again
		add_item(CMD_UNPLUG, -1);
		add_item(CMD_PLUG_CONST, 32767);
		add_item(CMD_PLUG_SRC, -32768);    // starts below
		add_item(CMD_TICK, -100);          // still below
		add_item(CMD_TICK, 32767);         // crosses from below
		add_item(CMD_UNPLUG, 32767);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			if (ph >= PHASES - 2) begin
				gain_set[ph]   = int'($signed(16'($urandom)));
				offset_set[ph] = int'($signed(16'($urandom)));
			end
			write_reg(REG_GAIN, gain_set[ph][CFG_W-1:0]);
			write_reg(REG_OFFSET, offset_set[ph][CFG_W-1:0]);
			@(negedge clk);
			calm = (ph == CALM_PHASE);
			begin
				int base;
				base = queued_total;
				while (queued_total - base < PHASE_ITEMS) begin
					if ($urandom_range(4) == 0)
						add_item(CMD_W'($urandom_range(3)), int'(rand_sample()));
					else
						add_pickup_run();
				end
			end
			if (ph == JAM_PHASE)
				jam_req = 1'b1;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (err_count == 0 && scaled_expect.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
